// File: design/weo_pkg.sv
package weo_pkg;

    localparam int ATAN_LEN = 24;
    localparam int CNT_W    = 16;
    localparam int CFG_W    = 24;
    localparam int POSE_W   = 32;
    localparam int HEAD_W   = 19;
    localparam int VEC_W    = 42;
    localparam int ANG_W    = 34;

    localparam logic [CNT_W:0]    WRAP_LIMIT  = 17'd10000;
    localparam logic signed [HEAD_W+1:0] PI_Q16     = 21'sd205887;
    localparam logic signed [HEAD_W+1:0] TWO_PI_Q16 = 21'sd411774;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [29:0] KINV_Q30 = 30'd652032874;

    localparam logic [0:0] CFG_DIST = 1'b0;
    localparam logic [0:0] CFG_IWB  = 1'b1;

    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [ANG_W-1:0] r;
        begin
            case (i)
                5'd0:  r = 34'sh3243F6A8;
                5'd1:  r = 34'sh1DAC6705;
                5'd2:  r = 34'sh0FADBAFC;
                5'd3:  r = 34'sh07F56EA6;
                5'd4:  r = 34'sh03FEAB76;
                5'd5:  r = 34'sh01FFD55B;
                5'd6:  r = 34'sh00FFFAAA;
                5'd7:  r = 34'sh007FFF55;
                5'd8:  r = 34'sh003FFFEA;
                5'd9:  r = 34'sh001FFFFD;
                5'd10: r = 34'sh000FFFFF;
                5'd11: r = 34'sh0007FFFF;
                5'd12: r = 34'sh0003FFFF;
                5'd13: r = 34'sh0001FFFF;
                5'd14: r = 34'sh0000FFFF;
                5'd15: r = 34'sh00007FFF;
                5'd16: r = 34'sh00003FFF;
                5'd17: r = 34'sh00001FFF;
                5'd18: r = 34'sh00000FFF;
                5'd19: r = 34'sh000007FF;
                5'd20: r = 34'sh000003FF;
                5'd21: r = 34'sh000001FF;
                5'd22: r = 34'sh000000FF;
                5'd23: r = 34'sh0000007F;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: design/wheel_encoder_odometry_core.sv
// Channel | Direction | tdata (low bit up)                        | tuser
// s_axis  | in        | encoder_left[15:0], encoder_right[31:16]  | -
// m_axis  | out       | pose_x[31:0], pose_y[63:32],              | -
//         |           | pose_heading[82:64], is_moving[83]        |
// The shared multiplier runs four products in turn and the CORDIC stage one step per cycle.
// A primed-only first word has its result in the cycle after accept. s_tready stays low while
// a word is in work or its result waits on m_tready, and returns in the cycle after the result
// is taken. aresetn is synchronous, active low, and clears pose, previous counts and the
// primed flag; configuration returns to its reset values.
module wheel_encoder_odometry_core
    import weo_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // encoder_left, encoder_right
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // pose_x, pose_y, pose_heading, is_moving
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int NSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIFF, ST_MUL_TURN, ST_MUL_IWB, ST_HEAD, ST_MUL_MEAN,
        ST_MUL_KINV, ST_ROT_INIT, ST_ROT, ST_ACC, ST_OUT
    } state_t;

    state_t state_reg;
    logic [CFG_W-1:0] dist_reg, iwb_reg;
    logic [CNT_W-1:0] last_l_reg, last_r_reg;
    logic primed_reg, moving_reg;
    logic signed [HEAD_W-1:0] head_reg;
    logic signed [POSE_W-1:0] x_reg, y_reg;
    logic signed [CNT_W+1:0] dl_reg, dr_reg;
    logic signed [63:0] prod_reg;
    logic signed [VEC_W-1:0] vx_reg, vy_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic [4:0] step_reg;

    logic signed [63:0] rnd8, rnd24, rnd13, rnd30;
    assign rnd8  = (prod_reg + 64'sd128) >>> 8;
    assign rnd24 = (prod_reg + 64'sd8388608) >>> 24;
    assign rnd13 = (prod_reg + 64'sd4096) >>> 13;
    assign rnd30 = (prod_reg + 64'sd536870912) >>> 30;

    // shared multiplier: operands chosen by state
    logic signed [33:0] mul_a;
    logic signed [30:0] mul_b;
    logic signed [63:0] mul_p;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_TURN: begin
                mul_a = 34'(dr_reg - dl_reg);
                mul_b = $signed({7'd0, dist_reg});
            end
            ST_MUL_IWB: begin
                mul_a = 34'(rnd8);
                mul_b = $signed({7'd0, iwb_reg});
            end
            ST_MUL_MEAN: begin
                mul_a = 34'(dl_reg + dr_reg);
                mul_b = $signed({7'd0, dist_reg});
            end
            ST_MUL_KINV: begin
                mul_a = 34'(rnd13);
                mul_b = $signed({1'd0, KINV_Q30});
            end
            default: ;
        endcase
        mul_p = 64'(mul_a * mul_b);
    end

    function automatic logic signed [CNT_W+1:0] unwrap(input logic [CNT_W-1:0] now_v,
                                                        input logic [CNT_W-1:0] old_v);
        logic signed [CNT_W+1:0] d;
        begin
            d = $signed({2'b00, now_v}) - $signed({2'b00, old_v});
            if (d > $signed({1'b0, WRAP_LIMIT}))
                d = d - 18'sd65536;
            else if (d < -$signed({1'b0, WRAP_LIMIT}))
                d = d + 18'sd65536;
            return d;
        end
    endfunction

    function automatic logic signed [POSE_W-1:0] sat_add(input logic signed [POSE_W-1:0] a,
                                                          input logic signed [VEC_W-1:0] b);
        logic signed [VEC_W:0] s;
        begin
            s = (VEC_W+1)'(a) + (VEC_W+1)'(b);
            if (s > (VEC_W+1)'(32'sh7FFFFFFF))
                return 32'sh7FFFFFFF;
            else if (s < -(VEC_W+1)'(33'sh080000000))
                return 32'sh80000000;
            return s[POSE_W-1:0];
        end
    endfunction

    logic signed [HEAD_W+1:0] turn_c, h_c;
    always_comb begin
        if (rnd24 > 64'(TWO_PI_Q16))
            turn_c = TWO_PI_Q16;
        else if (rnd24 < -64'(TWO_PI_Q16))
            turn_c = -TWO_PI_Q16;
        else
            turn_c = rnd24[HEAD_W+1:0];
        h_c = (HEAD_W+2)'(head_reg) + turn_c;
        if (h_c > PI_Q16)
            h_c = h_c - TWO_PI_Q16;
        else if (h_c < -PI_Q16)
            h_c = h_c + TWO_PI_Q16;
    end

    logic signed [VEC_W-1:0] sx, sy, vxr, vyr;
    assign sx  = vx_reg >>> step_reg;
    assign sy  = vy_reg >>> step_reg;
    assign vxr = (vx_reg + VEC_W'(8)) >>> 4;
    assign vyr = (vy_reg + VEC_W'(8)) >>> 4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            dist_reg   <= 24'd366327;
            iwb_reg    <= 24'd284939;
            last_l_reg <= '0;
            last_r_reg <= '0;
            primed_reg <= 1'b0;
            moving_reg <= 1'b0;
            head_reg   <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_DIST: dist_reg <= cfg_data;
                    CFG_IWB:  iwb_reg  <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        dl_reg     <= unwrap(s_tdata[15:0], last_l_reg);
                        dr_reg     <= unwrap(s_tdata[31:16], last_r_reg);
                        last_l_reg <= s_tdata[15:0];
                        last_r_reg <= s_tdata[31:16];
                        primed_reg <= 1'b1;
                        moving_reg <= 1'b0;
                        state_reg  <= primed_reg ? ST_DIFF : ST_OUT;
                    end
                end
                ST_DIFF: begin
                    moving_reg <= (dl_reg != 0) || (dr_reg != 0);
                    state_reg  <= ST_MUL_TURN;
                end
                ST_MUL_TURN: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_MUL_IWB;
                end
                ST_MUL_IWB: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_HEAD;
                end
                ST_HEAD: begin
                    head_reg  <= h_c[HEAD_W-1:0];
                    state_reg <= ST_MUL_MEAN;
                end
                ST_MUL_MEAN: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_MUL_KINV;
                end
                ST_MUL_KINV: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_ROT_INIT;
                end
                ST_ROT_INIT: begin
                    z_reg    <= ANG_W'(head_reg) <<< 14;
                    step_reg <= '0;
                    if ((ANG_W'(head_reg) <<< 14) > HALF_PI_Q30) begin
                        z_reg  <= (ANG_W'(head_reg) <<< 14) - HALF_PI_Q30;
                        vx_reg <= '0;
                        vy_reg <= rnd30[VEC_W-1:0];
                    end else if ((ANG_W'(head_reg) <<< 14) < -HALF_PI_Q30) begin
                        z_reg  <= (ANG_W'(head_reg) <<< 14) + HALF_PI_Q30;
                        vx_reg <= '0;
                        vy_reg <= -rnd30[VEC_W-1:0];
                    end else begin
                        vx_reg <= rnd30[VEC_W-1:0];
                        vy_reg <= '0;
                    end
                    state_reg <= ST_ROT;
                end
                ST_ROT: begin
                    if (z_reg >= 0) begin
                        vx_reg <= vx_reg - sy;
                        vy_reg <= vy_reg + sx;
                        z_reg  <= z_reg - atan_q30(step_reg);
                    end else begin
                        vx_reg <= vx_reg + sy;
                        vy_reg <= vy_reg - sx;
                        z_reg  <= z_reg + atan_q30(step_reg);
                    end
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(NSTEPS - 1))
                        state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    x_reg     <= sat_add(x_reg, vxr);
                    y_reg     <= sat_add(y_reg, vyr);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_tready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {4'd0, moving_reg, head_reg, y_reg, x_reg};

endmodule
